@@ hdl/assert_macros.svh @@
// Assertion macros used by the RTL. Every macro samples on clk
// and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define ASSERT_NEXT(label, trig, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (expr)) else $error(msg);

// A condition that must hold in the same cycle as a trigger.
`define ASSERT_IMPL(label, trig, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (expr)) else $error(msg);

`endif

@@ hdl/ifrc_pkg.sv @@
// ----------------------------------------------------------------------------
// ifrc_pkg: types and codes of the image flip, rotate and crop block
// Request and response beat layouts and the command codes.
// ----------------------------------------------------------------------------
package ifrc_pkg;

  localparam logic [2:0] CMD_START = 3'd0;
  localparam logic [2:0] CMD_WRITE = 3'd1;
  localparam logic [2:0] CMD_READ  = 3'd2;
  localparam logic [2:0] CMD_FLIPR = 3'd3;
  localparam logic [2:0] CMD_FLIPC = 3'd4;
  localparam logic [2:0] CMD_ROTCW = 3'd5;
  localparam logic [2:0] CMD_ROTCCW = 3'd6;
  localparam logic [2:0] CMD_CLIP  = 3'd7;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [15:0] pixel_in;
    logic [1:0]         turns;
    logic [6:0]         new_rows;
    logic [6:0]         new_cols;
    logic [6:0]         clip_left;
    logic [6:0]         clip_right;
    logic [6:0]         clip_top;
    logic [6:0]         clip_bottom;
  } req_t;

  typedef struct packed {
    logic signed [15:0] pixel_out;
    logic [6:0]         rows_now;
    logic [6:0]         cols_now;
    logic               status;
  } rsp_t;

endpackage

@@ hdl/image_flip_rotate_crop.sv @@
// ----------------------------------------------------------------------------
// image_flip_rotate_crop: small image store with flips, rotations and crop
// Two pixel banks; whole-image commands copy one bank into the other.
// ----------------------------------------------------------------------------
//  channel | signals                 | direction | beat
//  req     | req_valid, req_stall    | in        | one command (req_t)
//  rsp     | rsp_valid, rsp_stall    | out       | one result (rsp_t)
//
// Write, read, start with bad dimensions and a bad clip window finish without
// a pass. Start, flips, rotations and a valid clip make one pass over every
// store entry, one read and one write a cycle.
// No clearing pass follows reset: entries outside the image are never read
// back, and every pass writes zeros there.
// A new command is taken while an earlier result still waits under rsp_stall;
// its own result waits until the output register is free.
`include "assert_macros.svh"

module image_flip_rotate_crop
  import ifrc_pkg::*;
#(
  parameter int MAX_DIM    = 64,
  parameter int PIXEL_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int CELLS = MAX_DIM * MAX_DIM;
  localparam int AW = $clog2(CELLS);
  localparam int CW = $clog2(MAX_DIM);
  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int XW = (DW > 7) ? DW + 1 : 8;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DECODE, ST_RDWAIT, ST_PASS, ST_DRAIN, ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    M_COPY, M_FLIPR, M_FLIPC, M_ROT1, M_ROT2, M_ROT3, M_CLIP
  } map_t;

  logic [PIXEL_BITS-1:0] mem0 [CELLS];
  logic [PIXEL_BITS-1:0] mem1 [CELLS];
  logic [PIXEL_BITS-1:0] rd0, rd1;

  state_t            state;
  req_t              cur;
  logic              cur_bank;
  logic [DW-1:0]     row_count, col_count;
  map_t              mode;
  logic [DW-1:0]     new_r, new_c;
  logic [CW-1:0]     off_r, off_c;
  logic              zero_fill;
  logic              swap;
  logic [CW-1:0]     i_cnt, j_cnt;
  logic              wr_pend;
  logic [AW-1:0]     wr_addr;
  logic              wr_inside;
  logic              status;
  logic [15:0]       pout;

  state_t            state_next;
  map_t              mode_next;
  logic [DW-1:0]     new_r_next, new_c_next;
  logic [CW-1:0]     off_r_next, off_c_next;
  logic              zero_fill_next;
  logic              status_next;

  logic [CW-1:0]         rm1, cm1, sr, sc;
  logic [AW-1:0]         src_addr, dst_addr, one_addr, raddr, waddr;
  logic                  in_img;
  logic [PIXEL_BITS-1:0] rdata, wdata, pin_st;
  logic                  acc_ok, start_ok, clip_ok, wr_one, wen0, wen1;
  logic [1:0]            k;
  logic                  last;

  assign req_stall = (state != ST_IDLE);

  // Old dimensions minus one; they wrap for an empty image, where the
  // image test keeps the read data out.
  assign rm1 = CW'(row_count - DW'(1));
  assign cm1 = CW'(col_count - DW'(1));

  always_comb begin
    sr = i_cnt;
    sc = j_cnt;
    case (mode)
      M_FLIPR: sr = rm1 - i_cnt;
      M_FLIPC: sc = cm1 - j_cnt;
      M_ROT1: begin
        sr = rm1 - j_cnt;
        sc = i_cnt;
      end
      M_ROT2: begin
        sr = rm1 - i_cnt;
        sc = cm1 - j_cnt;
      end
      M_ROT3: begin
        sr = j_cnt;
        sc = cm1 - i_cnt;
      end
      M_CLIP: begin
        sr = i_cnt + off_r;
        sc = j_cnt + off_c;
      end
      default: ;
    endcase
  end

  assign src_addr = AW'(sr) * AW'(MAX_DIM) + AW'(sc);
  assign dst_addr = AW'(i_cnt) * AW'(MAX_DIM) + AW'(j_cnt);
  assign one_addr = AW'(cur.row) * AW'(MAX_DIM) + AW'(cur.col);
  assign in_img = !zero_fill && (DW'(i_cnt) < new_r) && (DW'(j_cnt) < new_c);
  assign last = (i_cnt == CW'(MAX_DIM - 1)) && (j_cnt == CW'(MAX_DIM - 1));

  assign acc_ok = (XW'(cur.row) < XW'(row_count)) && (XW'(cur.col) < XW'(col_count));
  assign start_ok = (cur.new_rows != 7'd0) && (cur.new_cols != 7'd0) &&
                    (XW'(cur.new_rows) <= XW'(MAX_DIM)) &&
                    (XW'(cur.new_cols) <= XW'(MAX_DIM));
  assign clip_ok = (cur.clip_left != 7'd0) && (cur.clip_left <= cur.clip_right) &&
                   (XW'(cur.clip_right) <= XW'(col_count)) &&
                   (cur.clip_top != 7'd0) && (cur.clip_top <= cur.clip_bottom) &&
                   (XW'(cur.clip_bottom) <= XW'(row_count));
  assign k = (cur.cmd == CMD_ROTCW) ? cur.turns : 2'(2'd0 - cur.turns);

  // A written pixel keeps the low PIXEL_BITS bits of its sign extension.
  always_comb begin
    logic signed [31:0] ext;
    ext = 32'(cur.pixel_in);
    pin_st = ext[PIXEL_BITS-1:0];
  end

  // Command decode: the pass setup, the read wait or the early finish of one command.
  always_comb begin
    state_next     = ST_PASS;
    mode_next      = M_COPY;
    new_r_next     = row_count;
    new_c_next     = col_count;
    off_r_next     = '0;
    off_c_next     = '0;
    zero_fill_next = 1'b0;
    status_next    = 1'b0;
    unique case (cur.cmd) inside
      CMD_START: begin
        zero_fill_next = 1'b1;
        new_r_next     = DW'(cur.new_rows);
        new_c_next     = DW'(cur.new_cols);
        if (!start_ok) begin
          status_next = 1'b1;
          state_next  = ST_FINISH;
        end
      end
      CMD_WRITE: begin
        status_next = !acc_ok;
        state_next  = ST_FINISH;
      end
      CMD_READ: begin
        status_next = !acc_ok;
        state_next  = acc_ok ? ST_RDWAIT : ST_FINISH;
      end
      CMD_FLIPR: mode_next = M_FLIPR;
      CMD_FLIPC: mode_next = M_FLIPC;
      CMD_ROTCW, CMD_ROTCCW: begin
        case (k)
          2'd1: mode_next = M_ROT1;
          2'd2: mode_next = M_ROT2;
          2'd3: mode_next = M_ROT3;
          default: mode_next = M_COPY;
        endcase
        if (k[0]) begin
          new_r_next = col_count;
          new_c_next = row_count;
        end
      end
      CMD_CLIP: begin
        mode_next  = M_CLIP;
        new_r_next = DW'(cur.clip_bottom - cur.clip_top + 7'd1);
        new_c_next = DW'(cur.clip_right - cur.clip_left + 7'd1);
        off_r_next = CW'(cur.clip_top - 7'd1);
        off_c_next = CW'(cur.clip_left - 7'd1);
        if (!clip_ok) begin
          status_next = 1'b1;
          state_next  = ST_FINISH;
        end
      end
      default: state_next = ST_FINISH;
    endcase
  end

  assign rdata = cur_bank ? rd1 : rd0;
  assign wr_one = (state == ST_DECODE) && (cur.cmd == CMD_WRITE) && acc_ok;
  // Passes write the bank that is not being read.
  assign wen0 = (wr_pend && cur_bank) || (wr_one && !cur_bank);
  assign wen1 = (wr_pend && !cur_bank) || (wr_one && cur_bank);
  assign waddr = wr_pend ? wr_addr : one_addr;
  assign wdata = wr_pend ? (wr_inside ? rdata : '0) : pin_st;
  assign raddr = (state == ST_DECODE) ? one_addr : src_addr;

  always_ff @(posedge clk) begin
    if (wen0) begin
      mem0[waddr] <= wdata;
    end
    rd0 <= mem0[raddr];
  end

  always_ff @(posedge clk) begin
    if (wen1) begin
      mem1[waddr] <= wdata;
    end
    rd1 <= mem1[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cur_bank  <= 1'b0;
      row_count <= '0;
      col_count <= '0;
      wr_pend   <= 1'b0;
      rsp_valid <= 1'b0;
      swap      <= 1'b0;
    end else begin
      // The finish state loads the output register itself.
      if (rsp_valid && !rsp_stall && (state != ST_FINISH)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_valid) begin
            cur    <= req;
            state  <= ST_DECODE;
            status <= 1'b0;
            pout   <= '0;
            swap   <= 1'b0;
          end
        end
        ST_DECODE: begin
          i_cnt     <= '0;
          j_cnt     <= '0;
          zero_fill <= zero_fill_next;
          new_r     <= new_r_next;
          new_c     <= new_c_next;
          mode      <= mode_next;
          off_r     <= off_r_next;
          off_c     <= off_c_next;
          status    <= status_next;
          state     <= state_next;
        end
        ST_RDWAIT: begin
          begin
            logic signed [31:0] ext;
            ext = 32'(signed'(rdata));
            pout <= ext[15:0];
          end
          state <= ST_FINISH;
        end
        ST_PASS: begin
          wr_pend   <= 1'b1;
          wr_addr   <= dst_addr;
          wr_inside <= in_img;
          if (j_cnt == CW'(MAX_DIM - 1)) begin
            j_cnt <= '0;
            i_cnt <= i_cnt + CW'(1);
          end else begin
            j_cnt <= j_cnt + CW'(1);
          end
          if (last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          wr_pend <= 1'b0;
          swap    <= 1'b1;
          state   <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!rsp_valid || !rsp_stall) begin
            if (swap) begin
              cur_bank  <= !cur_bank;
              row_count <= new_r;
              col_count <= new_c;
            end
            rsp.pixel_out <= pout;
            rsp.rows_now  <= 7'(swap ? new_r : row_count);
            rsp.cols_now  <= 7'(swap ? new_c : col_count);
            rsp.status    <= status;
            rsp_valid     <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_ALWAYS(a_one_bank_written, !(wen0 && wen1), "both pixel banks written at once")
  `ASSERT_IMPL(a_pass_other_bank, wr_pend, (cur_bank ? !wen1 : !wen0), "pass wrote source bank")
  `ASSERT_NEXT(a_accept_leaves_idle, req_valid && !req_stall, state == ST_DECODE, "accepted beat not decoded")
  `ASSERT_ALWAYS(a_dims_bounded, (XW'(row_count) <= XW'(MAX_DIM)) && (XW'(col_count) <= XW'(MAX_DIM)), "image dimensions exceed store")

endmodule
